// ===== hdl/gchc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gchc_pkg
// Shared types, constants and the gear table for the gear hash chunker.
// ----------------------------------------------------------------------------
package gchc_pkg;

   // Largest chunk the block will ever build, whatever max_chunk holds
   localparam int MAX_CHUNK_BYTES = 1048576;

   localparam int CFG_W        = 21;
   localparam int COUNT_W      = 21;
   localparam int HASH_W       = 64;
   localparam int BYTE_W       = 8;
   localparam int GEAR_DEPTH   = 256;
   localparam int MASK_BITS_CAP = 40;
   localparam int MASK_W_W     = 7;
   localparam int CSR_INDEX_W  = 2;

   localparam logic [HASH_W-1:0] GOLDEN = 64'h9E37_79B9_7F4A_7C15;
   localparam logic [HASH_W-1:0] MIXA   = 64'hBF58_476D_1CE4_E5B9;
   localparam logic [HASH_W-1:0] MIXB   = 64'h94D0_49BB_1331_11EB;

   localparam logic [CFG_W-1:0] MIN_CHUNK_RESET = 21'd2048;
   localparam logic [CFG_W-1:0] AVG_CHUNK_RESET = 21'd8192;
   localparam logic [CFG_W-1:0] MAX_CHUNK_RESET = 21'd65536;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_CHUNK = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AVG_CHUNK = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CHUNK = 2'd2;

   typedef enum logic [1:0] {
      REASON_CONTENT = 2'd0,
      REASON_MAX     = 2'd1,
      REASON_EOD     = 2'd2
   } close_reason_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              end_of_data;
   } req_beat_type;

   typedef struct packed {
      logic [COUNT_W-1:0] chunk_length;
      close_reason_type   close_reason;
      logic               final_chunk;
   } rsp_beat_type;

   // Settings as the datapath sees them, derived from the CSRs
   typedef struct packed {
      logic [COUNT_W-1:0] min_chunk;
      logic [COUNT_W-1:0] avg_chunk;
      logic [COUNT_W-1:0] cap;
      logic [HASH_W-1:0]  strict_mask;
      logic [HASH_W-1:0]  loose_mask;
   } cfg_type;

   typedef logic [HASH_W-1:0] gear_rom_type [GEAR_DEPTH];

   // SplitMix64 sequence, evaluated at elaboration only
   function automatic gear_rom_type splitmix_gears();
      gear_rom_type t;
      logic [HASH_W-1:0] x;
      logic [HASH_W-1:0] z;
      x = GOLDEN;
      for (int i = 0; i < GEAR_DEPTH; i++) begin
         x = x + GOLDEN;
         z = x;
         z = (z ^ (z >> 30)) * MIXA;
         z = (z ^ (z >> 27)) * MIXB;
         t[i] = z ^ (z >> 31);
      end
      return t;
   endfunction

   localparam gear_rom_type GEAR_ROM = splitmix_gears();

endpackage

// ===== hdl/gchc_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gchc_csr
// Chunk size registers and the mask and limit values derived from them.
// ----------------------------------------------------------------------------
module gchc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [gchc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gchc_pkg::CFG_W-1:0]          csr_write_data,
   output gchc_pkg::cfg_type                   cfg
);
   import gchc_pkg::*;

   logic [CFG_W-1:0] min_ff, min_in;
   logic [CFG_W-1:0] avg_ff, avg_in;
   logic [CFG_W-1:0] max_ff, max_in;

   logic [CFG_W-1:0]    avg_less_one;
   logic [MASK_W_W-1:0] log_avg;
   logic [MASK_W_W-1:0] strict_bits;
   logic [MASK_W_W-1:0] loose_bits;

   always_comb begin
      min_in = min_ff;
      avg_in = avg_ff;
      max_in = max_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MIN_CHUNK: min_in = csr_write_data;
            CSR_AVG_CHUNK: avg_in = csr_write_data;
            CSR_MAX_CHUNK: max_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= MIN_CHUNK_RESET;
         avg_ff <= AVG_CHUNK_RESET;
         max_ff <= MAX_CHUNK_RESET;
      end else begin
         min_ff <= min_in;
         avg_ff <= avg_in;
         max_ff <= max_in;
      end
   end

   // ceil(log2(avg)): bit length of avg-1, zero for avg of 0 or 1
   always_comb begin
      avg_less_one = avg_ff - 1'b1;
      log_avg      = '0;
      if (avg_ff > 1) begin
         for (int b = 0; b < CFG_W; b++) begin
            if (avg_less_one[b]) begin
               log_avg = MASK_W_W'(b + 1);
            end
         end
      end
   end

   // Clamp both widths to 1..MASK_BITS_CAP
   always_comb begin
      if (log_avg + MASK_W_W'(2) > MASK_W_W'(MASK_BITS_CAP)) begin
         strict_bits = MASK_W_W'(MASK_BITS_CAP);
      end else begin
         strict_bits = log_avg + MASK_W_W'(2);
      end
      if (log_avg < MASK_W_W'(3)) begin
         loose_bits = MASK_W_W'(1);
      end else if (log_avg - MASK_W_W'(2) > MASK_W_W'(MASK_BITS_CAP)) begin
         loose_bits = MASK_W_W'(MASK_BITS_CAP);
      end else begin
         loose_bits = log_avg - MASK_W_W'(2);
      end
   end

   always_comb begin
      cfg.min_chunk   = min_ff;
      cfg.avg_chunk   = avg_ff;
      cfg.strict_mask = ~({HASH_W{1'b1}} >> strict_bits);
      cfg.loose_mask  = ~({HASH_W{1'b1}} >> loose_bits);
      if (32'(max_ff) < 32'(MAX_CHUNK_BYTES)) begin
         cfg.cap = max_ff;
      end else begin
         cfg.cap = COUNT_W'(MAX_CHUNK_BYTES);
      end
   end

endmodule

// ===== hdl/gchc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gchc_core
// Gear hash and byte count of the open chunk, with the close decision.
// ----------------------------------------------------------------------------
module gchc_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  gchc_pkg::req_beat_type  beat,
   input  gchc_pkg::cfg_type       cfg,
   output logic                    close,
   output gchc_pkg::rsp_beat_type  result
);
   import gchc_pkg::*;

   logic [HASH_W-1:0]  hash_ff, hash_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic [HASH_W-1:0]  hash_sum;
   logic [COUNT_W-1:0] count_sum;
   logic [HASH_W-1:0]  mask;
   logic               in_window;
   logic               cut;
   logic               at_cap;

   always_comb begin
      hash_sum  = {hash_ff[HASH_W-2:0], 1'b0} + GEAR_ROM[beat.data_byte];
      count_sum = count_ff + 1'b1;
      in_window = (count_sum > cfg.min_chunk) && (count_sum <= cfg.cap);
      mask      = (count_sum <= cfg.avg_chunk) ? cfg.strict_mask : cfg.loose_mask;
      cut       = in_window && ((hash_sum & mask) == '0);
      at_cap    = count_sum >= cfg.cap;
      close     = cut || at_cap || beat.end_of_data;

      result.chunk_length = count_sum;
      result.final_chunk  = beat.end_of_data;
      if (cut) begin
         result.close_reason = REASON_CONTENT;
      end else if (at_cap) begin
         result.close_reason = REASON_MAX;
      end else begin
         result.close_reason = REASON_EOD;
      end
   end

   // Clear on every close taken on a step; the next chunk starts from a zero hash
   always_comb begin
      hash_in  = hash_ff;
      count_in = count_ff;
      if (step) begin
         if (close) begin
            hash_in  = '0;
            count_in = '0;
         end else begin
            hash_in  = hash_sum;
            count_in = count_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= '0;
         count_ff <= '0;
      end else begin
         hash_ff  <= hash_in;
         count_ff <= count_in;
      end
   end

   a_clear_after_close: assert property (@(posedge clock) disable iff (reset)
      step && close |=> count_ff == '0 && hash_ff == '0)
      else $error("chunk state not cleared after close");

   a_count_advances: assert property (@(posedge clock) disable iff (reset)
      step && !close |=> count_ff == $past(count_ff) + 1'b1)
      else $error("byte count did not advance");

   a_max_reason_at_cap: assert property (@(posedge clock) disable iff (reset)
      step && close && result.close_reason == REASON_MAX |->
         result.chunk_length >= cfg.cap)
      else $error("forced close below the size limit");

   a_cut_past_min: assert property (@(posedge clock) disable iff (reset)
      step && close && result.close_reason == REASON_CONTENT |->
         result.chunk_length > cfg.min_chunk && result.chunk_length <= cfg.cap)
      else $error("content cut outside the legal window");

endmodule

// ===== hdl/gear_hash_content_chunker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gear_hash_content_chunker
// Content-defined chunking of a byte stream with a 64-bit gear hash.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one data byte per beat, end_of_data set on the last byte of
//   the data. rsp channel: one beat per closed chunk with its length, the
//   reason it closed and whether it is the last chunk of the data. Most bytes
//   produce no rsp beat.
//   csr port: write min_chunk, avg_chunk and max_chunk by index while the
//   block is idle; new values apply from the next byte on.
//   Path: a chunk that closes on a byte goes from the input register through
//   the core into the result register, which drives rsp_valid and rsp_beat;
//   rsp_stall can hold it in either register on the way.
//   Throughput: one byte per cycle while rsp is not stalled. The per-byte
//   loop is the gear ROM lookup, the 64-bit shift-add and the masked zero
//   test on the new hash, all combinational in the core.
//   Reset: hash and count clear, the registers return to 2048 / 8192 / 65536,
//   both pipeline registers empty. The gear table is constant logic.
//   Stall: while rsp_stall holds a waiting beat, the core holds too; one more
//   byte is taken into the input register if it is empty, then req_stall rises.
// ----------------------------------------------------------------------------
module gear_hash_content_chunker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  gchc_pkg::req_beat_type            req_beat,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output gchc_pkg::rsp_beat_type            rsp_beat,
   input  logic                              csr_write_enable,
   input  logic [gchc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [gchc_pkg::CFG_W-1:0]        csr_write_data
);
   import gchc_pkg::*;

   // Input register: one byte waiting for the core
   logic         in_valid_ff, in_valid_in;
   req_beat_type in_beat_ff;

   // Result register: one chunk report waiting for the receiver
   logic         out_valid_ff, out_valid_in;
   rsp_beat_type out_beat_ff;

   logic         advance;
   logic         step;
   logic         close;
   rsp_beat_type result;
   cfg_type      cfg;

   gchc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   gchc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .beat   (in_beat_ff),
      .cfg    (cfg),
      .close  (close),
      .result (result)
   );

   // The core may run when the result register is free or being drained
   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      out_valid_in = out_valid_ff;
      // Refill the input register whenever its byte moves on or it is empty
      if (!in_valid_ff || advance) begin
         in_valid_in = req_valid;
      end
      // Load a new report, or drop the one just taken
      if (advance) begin
         out_valid_in = step && close;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload: no reset, load only on a beat
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_beat_ff <= req_beat;
      end
      if (step && close) begin
         out_beat_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_beat  = out_beat_ff;

endmodule
